@@ rtl/rrct_pkg.sv @@
`timescale 1ns / 1ps

package rrct_pkg;

  // Default store depth
  localparam int DEF_MAX_PROCS = 16;

  // Field widths
  localparam int ARR_W  = 16;
  localparam int PNUM_W = 5;
  localparam int RES_W  = 21;
  localparam int SUM_W  = 25;

  // Quantum after reset
  localparam logic [ARR_W-1:0] QUANTUM_RESET = 16'd4;

  // Sequencer states
  typedef enum logic [6:0] {
    S_LOAD     = 7'b0000001,
    S_READ     = 7'b0000010,
    S_EXEC     = 7'b0000100,
    S_SCAN_END = 7'b0001000,
    S_OUT_RD   = 7'b0010000,
    S_OUT_DIFF = 7'b0100000,
    S_OUT_EMIT = 7'b1000000
  } state_t;

endpackage

@@ rtl/round_robin_completion_times.sv @@
`timescale 1ns / 1ps

// Round-robin scheduler. Each accepted request loads one process (arrival, burst); a zero
// burst counts as one, a zero quantum as one, and requests past MAX_PROCS are dropped
// except that last_process still starts the run. The request with last_process set
// starts the simulation: every scan over the N loaded processes makes one store read and
// one pass through the single slice unit per process, plus one step to close the scan,
// and the number of scans follows from the bursts, the quantum and idle gaps before
// arrivals. Then one result per process leaves in load order, each through a read, a
// difference and an emit step; an emit waits while a stalled result is still held. in_stall
// is high from the last request until the final result sits in the output register; that
// result may still be waiting while the next set loads.
module round_robin_completion_times
  import rrct_pkg::*;
#(
  parameter int MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [ARR_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ARR_W-1:0]    arrival_time,
  input  logic [ARR_W-1:0]    burst_time,
  input  logic                last_process,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PNUM_W-1:0]   process_number,
  output logic [RES_W-1:0]    completion_time,
  output logic [RES_W-1:0]    turnaround_time,
  output logic [RES_W-1:0]    waiting_time,
  output logic [SUM_W-1:0]    total_waiting,
  output logic [SUM_W-1:0]    total_turnaround,
  output logic                last_result
);

  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int TW_RAW = ARR_W + 1 + CNT_W;
  localparam int TIME_W = (TW_RAW > RES_W) ? TW_RAW : RES_W;

  // Process stores
  logic [ARR_W-1:0]  arrival_mem   [MAX_PROCS];
  logic [ARR_W-1:0]  burst_mem     [MAX_PROCS];
  logic [ARR_W-1:0]  remaining_mem [MAX_PROCS];
  logic [TIME_W-1:0] completion_mem[MAX_PROCS];

  state_t            state, state_next;
  logic [CNT_W-1:0]  loaded_count, loaded_count_next;
  logic [CNT_W-1:0]  finished_count, finished_count_next;
  logic [TIME_W-1:0] current_time, current_time_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic              ran, ran_next;
  logic [ARR_W-1:0]  quantum;

  logic [ARR_W-1:0]  rd_arr, rd_bst, rd_rem;
  logic [TIME_W-1:0] rd_cmp;
  logic [TIME_W-1:0] tat;
  logic [SUM_W-1:0]  sum_wait, sum_tat;

  logic              in_acc;
  logic              store_free;
  logic [IDX_W-1:0]  load_idx;
  logic [ARR_W-1:0]  burst_fix;
  logic              idx_at_end;
  logic              runnable;
  logic [ARR_W-1:0]  slice;
  logic [TIME_W-1:0] time_after;
  logic              rem_we, cmp_we;
  logic [TIME_W-1:0] wt;
  logic              emit_load;

  assign in_stall   = (state != S_LOAD);
  assign in_acc     = in_valid && !in_stall;
  assign store_free = (loaded_count < CNT_W'(MAX_PROCS));
  assign load_idx   = loaded_count[IDX_W-1:0];
  assign burst_fix  = (burst_time == '0) ? ARR_W'(1) : burst_time;
  assign idx_at_end = ((CNT_W'(idx) + CNT_W'(1)) == loaded_count);

  // Shared slice unit: eligibility, min(remaining, quantum), time advance
  assign runnable   = (TIME_W'(rd_arr) <= current_time) && (rd_rem != '0);
  assign slice      = (rd_rem > quantum) ? quantum : rd_rem;
  assign time_after = current_time + TIME_W'(slice);
  assign rem_we     = (state == S_EXEC) && runnable;
  assign cmp_we     = rem_we && (rd_rem == slice);

  assign wt         = tat - TIME_W'(rd_bst);
  assign emit_load  = (state == S_OUT_EMIT) && (!out_valid || !out_stall);

  // Quantum register; zero is held as one
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_write) begin
      quantum <= (cfg_data == '0) ? ARR_W'(1) : cfg_data;
    end
  end

  // Store writes
  always_ff @(posedge clk) begin
    if (in_acc && store_free) begin
      arrival_mem[load_idx] <= arrival_time;
      burst_mem[load_idx]   <= burst_fix;
    end
    if (in_acc && store_free) begin
      remaining_mem[load_idx] <= burst_fix;
    end else if (rem_we) begin
      remaining_mem[idx] <= rd_rem - slice;
    end
    if (cmp_we) begin
      completion_mem[idx] <= time_after;
    end
  end

  // Registered store reads at the current index
  always_ff @(posedge clk) begin
    rd_arr <= arrival_mem[idx];
    rd_bst <= burst_mem[idx];
    rd_rem <= remaining_mem[idx];
    rd_cmp <= completion_mem[idx];
  end

  // Sequencer
  always_comb begin
    state_next          = state;
    loaded_count_next   = loaded_count;
    finished_count_next = finished_count;
    current_time_next   = current_time;
    idx_next            = idx;
    ran_next            = ran;
    case (state)
      S_LOAD: begin
        if (in_acc) begin
          if (store_free) begin
            loaded_count_next = loaded_count + CNT_W'(1);
          end
          if (last_process) begin
            current_time_next   = '0;
            finished_count_next = '0;
            idx_next            = '0;
            ran_next            = 1'b0;
            state_next          = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (runnable) begin
          ran_next          = 1'b1;
          current_time_next = time_after;
          if (cmp_we) begin
            finished_count_next = finished_count + CNT_W'(1);
          end
        end
        if (idx_at_end) begin
          state_next = S_SCAN_END;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_READ;
        end
      end
      S_SCAN_END: begin
        if (!ran) begin
          current_time_next = current_time + TIME_W'(1);
        end
        idx_next = '0;
        ran_next = 1'b0;
        if (finished_count == loaded_count) begin
          state_next = S_OUT_RD;
        end else begin
          state_next = S_READ;
        end
      end
      S_OUT_RD: begin
        state_next = S_OUT_DIFF;
      end
      S_OUT_DIFF: begin
        state_next = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        if (emit_load) begin
          if (idx_at_end) begin
            loaded_count_next   = '0;
            finished_count_next = '0;
            current_time_next   = '0;
            idx_next            = '0;
            state_next          = S_LOAD;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      loaded_count   <= '0;
      finished_count <= '0;
      current_time   <= '0;
      idx            <= '0;
      ran            <= 1'b0;
    end else begin
      state          <= state_next;
      loaded_count   <= loaded_count_next;
      finished_count <= finished_count_next;
      current_time   <= current_time_next;
      idx            <= idx_next;
      ran            <= ran_next;
    end
  end

  // Turnaround of the entry just read
  always_ff @(posedge clk) begin
    if (state == S_OUT_DIFF) begin
      tat <= rd_cmp - TIME_W'(rd_arr);
    end
  end

  // Running totals; cleared at every scan end, so they start from zero when the result phase opens
  always_ff @(posedge clk) begin
    if (state == S_SCAN_END) begin
      sum_wait <= '0;
      sum_tat  <= '0;
    end else if (emit_load) begin
      sum_wait <= sum_wait + SUM_W'(wt);
      sum_tat  <= sum_tat + SUM_W'(tat);
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      process_number   <= PNUM_W'(idx) + PNUM_W'(1);
      completion_time  <= rd_cmp[RES_W-1:0];
      turnaround_time  <= tat[RES_W-1:0];
      waiting_time     <= wt[RES_W-1:0];
      total_waiting    <= sum_wait + SUM_W'(wt);
      total_turnaround <= sum_tat + SUM_W'(tat);
      last_result      <= idx_at_end;
    end
  end

  // Finished processes never outnumber loaded ones
  a_finished_bound: assert property (@(posedge clk) disable iff (rst)
    finished_count <= loaded_count)
    else $error("finished count above loaded count");

  // Scan index stays inside the loaded set
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_EXEC || state == S_OUT_RD || state == S_OUT_EMIT)
      |-> (CNT_W'(idx) < loaded_count))
    else $error("scan index beyond loaded set");

  // A new result only follows an emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT_EMIT))
    else $error("result raised outside emit step");

  // Result phase starts only with every process finished
  a_all_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_END && state_next == S_OUT_RD) |-> (finished_count == loaded_count))
    else $error("results started with work left");

  // A finished set leaves the block empty
  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_EMIT && state_next == S_LOAD) |=> (loaded_count == '0))
    else $error("loaded count kept after last result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import rrct_pkg::*;

  typedef struct {
    logic [PNUM_W-1:0] proc_num;
    logic [RES_W-1:0]  done_at;
    logic [RES_W-1:0]  turnaround;
    logic [RES_W-1:0]  waited;
    logic [SUM_W-1:0]  sum_waited;
    logic [SUM_W-1:0]  sum_turnaround;
    logic              last_one;
  } sched_result_t;

  // Round-robin completion predictor and queue of results still due
  class schedule_board;
    logic [ARR_W-1:0] quantum;
    int unsigned      arr_s[DEF_MAX_PROCS];
    int unsigned      burst_s[DEF_MAX_PROCS];
    int unsigned      left_s[DEF_MAX_PROCS];
    int unsigned      done_s[DEF_MAX_PROCS];
    int unsigned      count;
    int unsigned      mismatches;
    sched_result_t    due_q[$];

    function new();
      quantum    = QUANTUM_RESET;
      count      = 0;
      mismatches = 0;
    endfunction

    function void set_quantum(logic [ARR_W-1:0] q);
      quantum = q;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // Store one process; on the final request run the schedule and queue results
    function void note_request(logic [ARR_W-1:0] arr, logic [ARR_W-1:0] burst, logic last);
      int unsigned       b;
      int unsigned       q;
      int unsigned       now;
      int unsigned       done_n;
      int unsigned       slice;
      int unsigned       tat;
      int unsigned       wt;
      bit                ran;
      longint unsigned   sum_w;
      longint unsigned   sum_t;
      sched_result_t     r;
      b = (burst == '0) ? 32'd1 : 32'(burst);
      if (count < DEF_MAX_PROCS) begin
        arr_s[count]   = 32'(arr);
        burst_s[count] = b;
        left_s[count]  = b;
        count++;
      end
      if (!last) return;
      q      = (quantum == '0) ? 32'd1 : 32'(quantum);
      now    = 0;
      done_n = 0;
      // Scan in load order until every process has finished
      while (done_n < count) begin
        ran = 0;
        for (int i = 0; i < count; i++) begin
          if (arr_s[i] <= now && left_s[i] > 0) begin
            slice = (left_s[i] > q) ? q : left_s[i];
            ran = 1;
            left_s[i] -= slice;
            now += slice;
            if (left_s[i] == 0) begin
              done_s[i] = now;
              done_n++;
            end
          end
        end
        if (!ran) now++;
      end
      sum_w = 0;
      sum_t = 0;
      for (int i = 0; i < count; i++) begin
        tat = done_s[i] - arr_s[i];
        wt  = tat - burst_s[i];
        sum_w += 64'(wt);
        sum_t += 64'(tat);
        r.proc_num       = PNUM_W'(i + 1);
        r.done_at        = RES_W'(done_s[i]);
        r.turnaround     = RES_W'(tat);
        r.waited         = RES_W'(wt);
        r.sum_waited     = SUM_W'(sum_w);
        r.sum_turnaround = SUM_W'(sum_t);
        r.last_one       = (i + 1 == count);
        due_q.push_back(r);
      end
      count = 0;
    endfunction

    // Compare one delivered result against the oldest one due
    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (due_q.size() == 0) begin
        flag($sformatf("unexpected result: proc %0d done %0d", got.proc_num, got.done_at));
        return;
      end
      exp = due_q.pop_front();
      if (got.proc_num !== exp.proc_num || got.done_at !== exp.done_at ||
          got.turnaround !== exp.turnaround || got.waited !== exp.waited ||
          got.sum_waited !== exp.sum_waited || got.sum_turnaround !== exp.sum_turnaround ||
          got.last_one !== exp.last_one) begin
        flag($sformatf({"result mismatch: exp proc %0d done %0d tat %0d wt %0d sums %0d/%0d ",
                        "last %0d; got proc %0d done %0d tat %0d wt %0d sums %0d/%0d last %0d"},
                       exp.proc_num, exp.done_at, exp.turnaround, exp.waited, exp.sum_waited,
                       exp.sum_turnaround, exp.last_one, got.proc_num, got.done_at,
                       got.turnaround, got.waited, got.sum_waited, got.sum_turnaround,
                       got.last_one));
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [ARR_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ARR_W-1:0]  arrival_time = '0;
  logic [ARR_W-1:0]  burst_time = '0;
  logic              last_process = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PNUM_W-1:0] process_number;
  logic [RES_W-1:0]  completion_time;
  logic [RES_W-1:0]  turnaround_time;
  logic [RES_W-1:0]  waiting_time;
  logic [SUM_W-1:0]  total_waiting;
  logic [SUM_W-1:0]  total_turnaround;
  logic              last_result;

  schedule_board board = new();
  bit            calm = 1'b0;
  int            requests_sent = 0;

  round_robin_completion_times dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .last_process     (last_process),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .process_number   (process_number),
    .completion_time  (completion_time),
    .turnaround_time  (turnaround_time),
    .waiting_time     (waiting_time),
    .total_waiting    (total_waiting),
    .total_turnaround (total_turnaround),
    .last_result      (last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input logic [ARR_W-1:0] arr, input logic [ARR_W-1:0] burst,
                              input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    arrival_time <= arr;
    burst_time   <= burst;
    last_process <= last;
    do @(posedge clk); while (in_stall);
    board.note_request(arr, burst, last);
    requests_sent++;
  endtask

  // Drop valid and wait until every due result has been delivered
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [ARR_W-1:0] q);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= q;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_quantum(q);
  endtask

  // One random process set; large quantum allows full-range bursts
  task automatic send_random_set();
    int               n;
    bit               wide;
    logic [ARR_W-1:0] arr;
    logic [ARR_W-1:0] burst;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 16);
    wide = (board.quantum >= 4096);
    calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      arr = wide ? ARR_W'($urandom_range(0, 255)) : ARR_W'($urandom_range(0, 63));
      if (wide) burst = ARR_W'($urandom_range(0, 65535));
      else burst = ($urandom_range(0, 7) == 0) ? '0 : ARR_W'($urandom_range(1, 40));
      send_request(arr, burst, i == n - 1);
    end
  endtask

  // Check accepted results and pick random stall stretches
  initial begin
    sched_result_t got;
    int            stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.proc_num       = process_number;
        got.done_at        = completion_time;
        got.turnaround     = turnaround_time;
        got.waited         = waiting_time;
        got.sum_waited     = total_waiting;
        got.sum_turnaround = total_turnaround;
        got.last_one       = last_result;
        board.check_result(got);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Stimulus: directed sets, then random sets across quantum settings
  initial begin
    int phase;
    int sets;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Late arrival with zero burst, then longest burst at the reset quantum
    send_request(16'hFFFF, 16'h0000, 1'b1);
    send_request(16'h0000, 16'hFFFF, 1'b1);

    // Fill the store; the extras are dropped and the last one still starts the run
    for (int i = 0; i < 18; i++) begin
      send_request(ARR_W'(i), (i == 5) ? 16'd0 : ARR_W'(i + 1), i == 17);
    end

    phase = 0;
    sets  = 0;
    while (requests_sent < 310) begin
      if (sets % 4 == 0) begin
        case (phase % 6)
          0: write_quantum(16'd1);
          1: write_quantum(16'd0);
          2: write_quantum(16'hFFFF);
          3: write_quantum(ARR_W'($urandom_range(2, 8)));
          4: write_quantum(ARR_W'($urandom_range(4096, 65535)));
          default: write_quantum(ARR_W'($urandom_range(1, 32)));
        endcase
        phase++;
      end
      send_random_set();
      sets++;
    end

    calm = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
